// File: sv/brbo_pkg.sv
// Shared types, sizes and helpers for the byte ring buffer with overwrite.
// No dependencies; every other file of the block imports this package.
package brbo_pkg;

  localparam int DEPTH          = 256;
  localparam int MAX_READ_BURST = 64;
  localparam int AW             = $clog2(DEPTH);
  localparam int CW             = $clog2(DEPTH + 1);
  localparam int LEN_W          = 16;
  localparam int BURST_CW       = $clog2(MAX_READ_BURST + 1);
  localparam int CMDQ_DEPTH     = 4;
  localparam int OQ_DEPTH       = 4;

  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_READ     = 2'd1,
    ACT_SET_TAIL = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_INFO  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] request_length;
    logic [7:0]       tail_index_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte_out;
    logic       has_data;
    logic       last;
    logic       write_accepted;
    logic [8:0] bytes_available;
    logic [7:0] tail_index;
  } out_item_t;

  // One unit of work handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_t           kind;
    logic                wr_en;
    logic [AW-1:0]       addr;
    logic [7:0]          data;
    logic [BURST_CW-1:0] count;
    logic                accepted;
    logic [CW-1:0]       avail;
    logic [AW-1:0]       tail;
  } cmd_t;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [CW-1:0] fill_of(input logic [AW-1:0] head,
                                            input logic [AW-1:0] tail,
                                            input logic          full);
    logic [CW-1:0] h;
    logic [CW-1:0] t;
    h = CW'(head);
    t = CW'(tail);
    if (full) return CW'(DEPTH);
    if (h >= t) return h - t;
    return CW'(DEPTH) - (t - h);
  endfunction

endpackage

// File: sv/brbo_front.sv
// Front end: accepts input requests, keeps the ring indices and burst state,
// and turns each request into one back-end command. Depends on brbo_pkg.
module brbo_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              req_take,
  input  brbo_pkg::in_item_t req,
  output brbo_pkg::cmd_t    cmd
);
  import brbo_pkg::*;

  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic             full_r, full_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] skip_r, skip_nxt;
  logic             drop_r, drop_nxt;
  logic             ow_r;

  logic [LEN_W-1:0] total;
  logic [CW-1:0]    fill;
  logic [CW-1:0]    space;
  logic [LEN_W-1:0] n_lim;
  logic [LEN_W-1:0] n_rd;
  logic [AW:0]      tail_sum;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    full_nxt = full_r;
    rem_nxt  = rem_r;
    skip_nxt = skip_r;
    drop_nxt = drop_r;
    total    = (req.request_length == '0) ? LEN_W'(1) : req.request_length;
    fill     = fill_of(head_r, tail_r, full_r);
    space    = CW'(DEPTH) - fill;
    n_lim    = (req.request_length < LEN_W'(fill)) ? req.request_length : LEN_W'(fill);
    n_rd     = (n_lim > LEN_W'(MAX_READ_BURST)) ? LEN_W'(MAX_READ_BURST) : n_lim;
    tail_sum = (AW+1)'(tail_r) + (AW+1)'(n_rd);
    cmd          = '0;
    cmd.kind     = CMD_INFO;
    cmd.data     = req.data_byte;
    case (action_t'(req.action))
      ACT_WRITE: begin
        // The first byte of a burst decides its fate for the whole burst.
        if (rem_r == '0) begin
          drop_nxt = 1'b0;
          skip_nxt = '0;
          if (total > LEN_W'(space)) begin
            if (!ow_r) begin
              drop_nxt = 1'b1;
            end else if (total > LEN_W'(DEPTH)) begin
              skip_nxt = total - LEN_W'(DEPTH);
              tail_nxt = head_r;
              full_nxt = 1'b0;
            end
          end
          rem_nxt = total;
        end
        rem_nxt = rem_nxt - LEN_W'(1);
        cmd.kind = CMD_WRITE;
        cmd.addr = head_nxt;
        if (!drop_nxt) begin
          if (skip_nxt != '0) begin
            skip_nxt = skip_nxt - LEN_W'(1);
          end else if (full_nxt) begin
            if (ow_r) begin
              cmd.wr_en = 1'b1;
              head_nxt  = next_pos(head_nxt);
              tail_nxt  = head_nxt;
            end
          end else begin
            cmd.wr_en = 1'b1;
            head_nxt  = next_pos(head_nxt);
            if (head_nxt == tail_nxt) full_nxt = 1'b1;
          end
        end
        cmd.accepted = !drop_nxt;
      end
      ACT_READ: begin
        if (n_rd != '0) begin
          cmd.kind  = CMD_READ;
          cmd.addr  = tail_r;
          cmd.count = BURST_CW'(n_rd);
          full_nxt  = 1'b0;
          tail_nxt  = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                   : AW'(tail_sum);
        end
      end
      ACT_SET_TAIL: begin
        if (9'(req.tail_index_in) < 9'(DEPTH)) tail_nxt = AW'(req.tail_index_in);
      end
      default: begin
      end
    endcase
    cmd.avail = fill_of(head_nxt, tail_nxt, full_nxt);
    cmd.tail  = tail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      full_r <= 1'b0;
      rem_r  <= '0;
      skip_r <= '0;
      drop_r <= 1'b0;
      ow_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) ow_r <= cfg_wr_data;
      if (req_take) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        full_r <= full_nxt;
        rem_r  <= rem_nxt;
        skip_r <= skip_nxt;
        drop_r <= drop_nxt;
      end
    end
  end

endmodule

// File: sv/brbo_cmdq.sv
// Short command queue between the front end and the back end.
// Depends on brbo_pkg for the command type and depth.
module brbo_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  brbo_pkg::cmd_t cmd_in,
  output logic           full,
  input  logic           pop,
  output brbo_pkg::cmd_t cmd_out,
  output logic           empty
);
  import brbo_pkg::*;

  localparam int PW = $clog2(CMDQ_DEPTH);
  localparam int NW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          q_r [CMDQ_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [NW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == NW'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(CMDQ_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (do_pop) rp_r <= (rp_r == PW'(CMDQ_DEPTH - 1)) ? '0 : rp_r + PW'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + NW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - NW'(1);
    end
  end

endmodule

// File: sv/brbo_back.sv
// Back end: owns the byte store, executes commands in order, streams read
// bytes one per cycle while the output queue has room, and buffers results
// in a small output queue. Depends on brbo_pkg.
module brbo_back (
  input  logic                clk,
  input  logic                rst_n,
  input  brbo_pkg::cmd_t      cmd,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  output brbo_pkg::out_item_t res,
  output logic                res_empty,
  input  logic                res_pop
);
  import brbo_pkg::*;

  localparam int OPW = $clog2(OQ_DEPTH);
  localparam int ONW = $clog2(OQ_DEPTH + 1);

  logic [7:0]          mem [DEPTH];
  logic [7:0]          mem_q_r;

  logic                active_r, active_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [BURST_CW-1:0] left_r, left_nxt;
  out_item_t           meta_r, meta_nxt;

  logic                vld_b_r;
  out_item_t           res_b_r;
  out_item_t           iss_res;
  out_item_t           push_item;

  out_item_t           oq_r [OQ_DEPTH];
  logic [OPW-1:0]      oq_wp_r, oq_rp_r;
  logic [ONW-1:0]      oq_cnt_r;
  logic                oq_pop;

  logic                can_issue, iss;
  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr;

  assign can_issue = ((ONW+1)'(oq_cnt_r) + (ONW+1)'(vld_b_r)) < (ONW+1)'(OQ_DEPTH);

  always_comb begin
    cmd_pop    = 1'b0;
    iss        = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    rd_addr    = addr_r;
    active_nxt = active_r;
    addr_nxt   = addr_r;
    left_nxt   = left_r;
    meta_nxt   = meta_r;
    iss_res    = '0;
    if (can_issue) begin
      if (active_r) begin
        iss      = 1'b1;
        rd_en    = 1'b1;
        iss_res  = meta_r;
        iss_res.last = (left_r == BURST_CW'(1));
        addr_nxt = next_pos(addr_r);
        left_nxt = left_r - BURST_CW'(1);
        if (left_r == BURST_CW'(1)) active_nxt = 1'b0;
      end else if (!cmd_empty) begin
        cmd_pop = 1'b1;
        iss     = 1'b1;
        iss_res.bytes_available = 9'(cmd.avail);
        iss_res.tail_index      = 8'(cmd.tail);
        iss_res.last            = 1'b1;
        case (cmd.kind)
          CMD_WRITE: begin
            wr_en = cmd.wr_en;
            iss_res.write_accepted = cmd.accepted;
          end
          CMD_READ: begin
            rd_en   = 1'b1;
            rd_addr = cmd.addr;
            iss_res.has_data = 1'b1;
            iss_res.last     = (cmd.count == BURST_CW'(1));
            if (cmd.count != BURST_CW'(1)) begin
              active_nxt = 1'b1;
              addr_nxt   = next_pos(cmd.addr);
              left_nxt   = cmd.count - BURST_CW'(1);
              meta_nxt   = iss_res;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[cmd.addr] <= cmd.data;
    if (rd_en) mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      vld_b_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      vld_b_r  <= iss;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    left_r  <= left_nxt;
    meta_r  <= meta_nxt;
    res_b_r <= iss_res;
  end

  always_comb begin
    push_item = res_b_r;
    if (res_b_r.has_data) push_item.data_byte_out = mem_q_r;
  end

  assign res_empty = (oq_cnt_r == '0);
  assign oq_pop    = res_pop && !res_empty;
  assign res       = oq_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (vld_b_r) oq_r[oq_wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (vld_b_r) oq_wp_r <= (oq_wp_r == OPW'(OQ_DEPTH - 1)) ? '0 : oq_wp_r + OPW'(1);
      if (oq_pop) oq_rp_r <= (oq_rp_r == OPW'(OQ_DEPTH - 1)) ? '0 : oq_rp_r + OPW'(1);
      if (vld_b_r && !oq_pop) oq_cnt_r <= oq_cnt_r + ONW'(1);
      else if (oq_pop && !vld_b_r) oq_cnt_r <= oq_cnt_r - ONW'(1);
    end
  end

endmodule

// File: sv/byte_ring_buffer_overwrite.sv
// Top level of the byte ring buffer with overwrite of the oldest data.
// Depends on brbo_pkg, brbo_front, brbo_cmdq and brbo_back.
//
//   channel   ports                          handshake
//   -------   ----------------------------   ---------------------------------
//   input     push, full, in_item            taken when push && !full
//   result    empty, pop, out_item           taken when pop && !empty
//   config    cfg_wr_en, cfg_wr_data         written when cfg_wr_en is high
//
// Write, set-tail and other single-result requests are taken one per cycle
// while full is low; a read of n bytes holds the back end until all n bytes
// are issued, one byte per cycle through the single read port of the byte
// store, as long as the output queue has room.
// Reset (rst_n low, synchronous) empties the ring, closes any open burst and
// turns overwrite off. The store itself is not cleared.
// A stalled result side fills the output queue and then the command queue,
// after which full goes high; nothing is lost or reordered.
module byte_ring_buffer_overwrite (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  brbo_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output brbo_pkg::out_item_t out_item,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);
  import brbo_pkg::*;

  // The front end commits each request to the ring state in the cycle it is
  // taken, so the following request already sees the new head, tail and
  // fill level. Every byte move is deferred to the back end as a command.
  cmd_t fe_cmd;
  cmd_t be_cmd;
  logic take;
  logic cq_full;
  logic cq_empty;
  logic cq_pop;

  assign full = cq_full;
  assign take = push && !cq_full;

  brbo_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_take    (take),
    .req         (in_item),
    .cmd         (fe_cmd)
  );

  // Commands reach the store in request order, so a write that reuses a
  // freed slot can never overtake the read that freed it.
  brbo_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (take),
    .cmd_in  (fe_cmd),
    .full    (cq_full),
    .pop     (cq_pop),
    .cmd_out (be_cmd),
    .empty   (cq_empty)
  );

  brbo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (be_cmd),
    .cmd_empty (cq_empty),
    .cmd_pop   (cq_pop),
    .res       (out_item),
    .res_empty (empty),
    .res_pop   (pop)
  );

endmodule
